FILE: rtl/nte_pkg.sv
`timescale 1ns / 1ps

package nte_pkg;

  localparam int CHAR_W    = 8;
  localparam int POS_W     = 5;
  localparam int RUN_MAX   = 5;
  localparam int LEN_W     = 3;
  localparam int ROW_IDX_W = 7;

  localparam logic [CHAR_W-1:0] CODE_FIRST = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LAST  = 8'h4C;
  localparam logic [CHAR_W-1:0] STOP_A     = 8'h52;
  localparam logic [CHAR_W-1:0] STOP_B     = 8'h53;

  // run of characters; first character in the top byte
  typedef struct packed {
    logic [LEN_W-1:0]          len;
    logic [RUN_MAX*CHAR_W-1:0] chars;
  } run_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  function automatic run_t expand_row(input logic [ROW_IDX_W-1:0] idx);
    run_t r;
    unique case (idx)
      7'd0:  r = '{3'd2, 40'hA47F000000};
      7'd1:  r = '{3'd2, 40'h7FB3000000};
      7'd2:  r = '{3'd2, 40'hAEB4000000};
      7'd3:  r = '{3'd2, 40'hA8AD000000};
      7'd4:  r = '{3'd2, 40'hB3A7000000};
      7'd5:  r = '{3'd2, 40'hA7A4000000};
      7'd6:  r = '{3'd2, 40'hB37F000000};
      7'd7:  r = '{3'd2, 40'hA4B1000000};
      7'd8:  r = '{3'd2, 40'hAEAD000000};
      7'd9:  r = '{3'd2, 40'hB1A4000000};
      7'd10: r = '{3'd2, 40'hB27F000000};
      7'd11: r = '{3'd2, 40'hA0B3000000};
      7'd12: r = '{3'd2, 40'hA0AD000000};
      7'd13: r = '{3'd2, 40'hB3AE000000};
      7'd14: r = '{3'd2, 40'hA7A0000000};
      7'd15: r = '{3'd2, 40'hADA6000000};
      7'd16: r = '{3'd2, 40'hA8B3000000};
      7'd17: r = '{3'd2, 40'hA8B2000000};
      7'd18: r = '{3'd2, 40'hA4A0000000};
      7'd19: r = '{3'd2, 40'hB5A4000000};
      7'd20: r = '{3'd2, 40'hA0B1000000};
      7'd21: r = '{3'd2, 40'hB2B3000000};
      7'd22: r = '{3'd2, 40'hABA4000000};
      7'd23: r = '{3'd2, 40'hAEB1000000};
      7'd24: r = '{3'd2, 40'hB3A4000000};
      7'd25: r = '{3'd2, 40'hA0B2000000};
      7'd26: r = '{3'd2, 40'hB8AE000000};
      7'd27: r = '{3'd2, 40'hB87F000000};
      7'd28: r = '{3'd2, 40'hB17F000000};
      7'd29: r = '{3'd2, 40'h7FA1000000};
      7'd30: r = '{3'd2, 40'hA4AD000000};
      7'd31: r = '{3'd2, 40'hACA4000000};
      7'd32: r = '{3'd3, 40'hA47FB30000};
      7'd33: r = '{3'd2, 40'h9D7F000000};
      7'd34: r = '{3'd2, 40'hA4B2000000};
      7'd35: r = '{3'd5, 40'hA47FB8AEB4};
      7'd36: r = '{3'd2, 40'hB2A4000000};
      7'd37: r = '{3'd2, 40'hADA4000000};
      7'd38: r = '{3'd2, 40'h7FA7000000};
      7'd39: r = '{3'd2, 40'h887F000000};
      7'd40: r = '{3'd3, 40'hAEB4B10000};
      7'd41: r = '{3'd3, 40'h98AEB40000};
      7'd42: r = '{3'd2, 40'hADA3000000};
      7'd43: r = '{3'd2, 40'hAEB6000000};
      7'd44: r = '{3'd2, 40'h7FA2000000};
      7'd45: r = '{3'd3, 40'h7FB6A00000};
      7'd46: r = '{3'd3, 40'hAEACA40000};
      7'd47: r = '{3'd3, 40'hA0B1A40000};
      7'd48: r = '{3'd3, 40'h93A7A40000};
      7'd49: r = '{3'd3, 40'hB3C0B20000};
      7'd50: r = '{3'd2, 40'hB4B3000000};
      7'd51: r = '{3'd2, 40'hADB3000000};
      7'd52: r = '{3'd3, 40'hB3A7A40000};
      7'd53: r = '{3'd3, 40'hB8AEB40000};
      7'd54: r = '{3'd3, 40'hA8ADA60000};
      7'd55: r = '{3'd3, 40'hA7A0B30000};
      7'd56: r = '{3'd3, 40'hA0ADA30000};
      7'd57: r = '{3'd3, 40'hA5AEB10000};
      7'd58: r = '{3'd3, 40'hA0ABAB0000};
      7'd59: r = '{3'd4, 40'hA7A4B1A400};
      7'd60: r = '{3'd4, 40'hB3A7A0B300};
      7'd61: r = '{3'd4, 40'hA7A0B5A400};
      7'd62: r = '{3'd4, 40'hB1A0A8AD00};
      7'd63: r = '{3'd4, 40'hB3A7A8B200};
      7'd64: r = '{3'd4, 40'hA8A6A7B300};
      7'd65: r = '{3'd4, 40'hB6A8B3A700};
      7'd66: r = '{3'd4, 40'hAEB4ABA300};
      7'd67: r = '{3'd5, 40'hA0B3B3ABA4};
      default: r = '{3'd0, 40'h0};
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/nte_in_if.sv
`timescale 1ns / 1ps

interface nte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code;
  logic       start_of_message;

  modport source (output valid, output code, output start_of_message, input ready);
  modport sink   (input valid, input code, input start_of_message, output ready);
endinterface

FILE: rtl/nte_out_if.sv
`timescale 1ns / 1ps

interface nte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [4:0] position;
  logic       last_of_run;
  logic       terminator;

  modport source (output valid, output char_code, output position, output last_of_run,
                  output terminator, input ready);
  modport sink   (input valid, input char_code, input position, input last_of_run,
                  input terminator, output ready);
endinterface

FILE: rtl/ngram_text_expander.sv
`timescale 1ns / 1ps

// N-gram message text expander.
// in_ch carries one encoded byte per item (code, start_of_message); out_ch
// carries one decoded character per item (char_code, position, last_of_run,
// terminator). Both are valid/ready; an item moves when both are high.
// Codes 0x09..0x4C expand through a constant run table to 2..5 characters;
// any other byte is one literal character, and a literal 0x52/0x53 ends the
// message: following bytes give nothing until start_of_message is seen.
// Characters at buffer index MESSAGE_BYTES or beyond are dropped.
// Timing: an accepted byte loads a run shift register; the sequencer then
// shifts out one character per cycle, while the output slot is free, into
// the output register. A byte dropped whole at the buffer end sends the
// block straight back to idle, and a byte ignored after a stop leaves it
// idle. in_ch.ready is high only when idle; the first character moves from
// the run shift register to the output register once the output slot is
// free. If the receiver stalls, the output register holds and the
// sequencer waits; the next byte can be taken while the final character
// still waits.
// Reset (rst_n low, synchronous) empties the output register, returns to
// idle and clears position and the stop flag, as if a message had begun.

module ngram_text_expander
  import nte_pkg::*;
#(
  parameter int MESSAGE_BYTES = 32
) (
  input  logic clk,
  input  logic rst_n,
  nte_in_if.sink    in_ch,
  nte_out_if.source out_ch
);

  localparam int WP_BITS = $clog2(MESSAGE_BYTES + 1);
  localparam int WP_W    = (WP_BITS > POS_W) ? WP_BITS : POS_W;
  localparam logic [WP_W-1:0] WP_LIMIT = WP_W'(MESSAGE_BYTES);
  localparam logic [WP_W-1:0] WP_FINAL = WP_W'(MESSAGE_BYTES - 1);

  state_t                    state_r, state_nxt;
  logic [WP_W-1:0]           wp_r, wp_nxt;
  logic                      stopped_r, stopped_nxt;
  logic [RUN_MAX*CHAR_W-1:0] chars_r, chars_nxt;
  logic [LEN_W-1:0]          rem_r, rem_nxt;
  logic                      is_stop_r, is_stop_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_term_r, out_term_nxt;

  logic              in_take, slot_free, emit_last;
  logic              code_in_table, lit_stop;
  logic [WP_W-1:0]   wp_base;
  run_t              row;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;

  assign code_in_table = (in_ch.code >= CODE_FIRST) && (in_ch.code <= CODE_LAST);
  assign lit_stop      = !code_in_table && ((in_ch.code == STOP_A) || (in_ch.code == STOP_B));
  assign row           = expand_row(ROW_IDX_W'(in_ch.code - CODE_FIRST));
  assign wp_base       = in_ch.start_of_message ? '0 : wp_r;

  // final character: end of run, or the last slot of the buffer
  assign emit_last = (rem_r == LEN_W'(1)) || (wp_r == WP_FINAL);

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    stopped_nxt   = stopped_r;
    chars_nxt     = chars_r;
    rem_nxt       = rem_r;
    is_stop_nxt   = is_stop_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_char_nxt  = out_char_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;
    out_term_nxt  = out_term_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          wp_nxt      = wp_base;
          is_stop_nxt = lit_stop;
          if (code_in_table) begin
            chars_nxt = row.chars;
            rem_nxt   = row.len;
          end else begin
            chars_nxt = {in_ch.code, {(RUN_MAX-1)*CHAR_W{1'b0}}};
            rem_nxt   = LEN_W'(1);
          end
          if (in_ch.start_of_message || !stopped_r) begin
            stopped_nxt = lit_stop;
            state_nxt   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (wp_r >= WP_LIMIT) begin
          state_nxt = ST_IDLE;          // buffer full: rest of run dropped
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = chars_r[RUN_MAX*CHAR_W-1 -: CHAR_W];
          out_pos_nxt   = wp_r[POS_W-1:0];
          out_last_nxt  = emit_last;
          out_term_nxt  = is_stop_r;
          chars_nxt     = {chars_r[(RUN_MAX-1)*CHAR_W-1:0], {CHAR_W{1'b0}}};
          rem_nxt       = rem_r - LEN_W'(1);
          wp_nxt        = wp_r + WP_W'(1);
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r    <= chars_nxt;
    rem_r      <= rem_nxt;
    is_stop_r  <= is_stop_nxt;
    out_char_r <= out_char_nxt;
    out_pos_r  <= out_pos_nxt;
    out_last_r <= out_last_nxt;
    out_term_r <= out_term_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.char_code   = out_char_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.terminator  = out_term_r;

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= WP_LIMIT)
    else $error("write position beyond buffer size");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (state_r == ST_EMIT))
    else $error("run ended without a last character");

  a_rem_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (rem_r != '0))
    else $error("emitting with empty run");

  // a new message may already be taken while the stop character waits
  a_stop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_term_r) |-> out_last_r)
    else $error("stop character not final");

endmodule
